// ----- rtl/i2cmrt_pkg.sv -----
package i2cmrt_pkg;

    // Default depth of the write byte buffer.
    localparam int WRITE_BUFFER_DEPTH = 16;

    // Reset value of the stretch limit register.
    localparam logic [7:0] STRETCH_LIMIT_RESET = 8'd200;

    // Stream word widths.
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;

    // Word kinds carried on the input tuser.
    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_START = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    // Bus phases, one-hot.
    typedef enum logic [17:0] {
        PH_IDLE     = 18'b000000000000000001,
        PH_ST_A     = 18'b000000000000000010,
        PH_ST_B     = 18'b000000000000000100,
        PH_ST_C     = 18'b000000000000001000,
        PH_TX_SET   = 18'b000000000000010000,
        PH_TX_HIGH  = 18'b000000000000100000,
        PH_TX_LOW   = 18'b000000000001000000,
        PH_ACK_SET  = 18'b000000000010000000,
        PH_ACK_HIGH = 18'b000000000100000000,
        PH_ACK_LOW  = 18'b000000001000000000,
        PH_RX_HIGH  = 18'b000000010000000000,
        PH_RX_LOW   = 18'b000000100000000000,
        PH_MA_SET   = 18'b000001000000000000,
        PH_MA_HIGH  = 18'b000010000000000000,
        PH_MA_LOW   = 18'b000100000000000000,
        PH_SP_A     = 18'b001000000000000000,
        PH_SP_B     = 18'b010000000000000000,
        PH_SP_C     = 18'b100000000000000000
    } t_phase;

    // Which byte of the transaction is on the bus, one-hot.
    typedef enum logic [3:0] {
        ITEM_ADDR_W = 4'b0001,
        ITEM_REG    = 4'b0010,
        ITEM_DATA   = 4'b0100,
        ITEM_ADDR_R = 4'b1000
    } t_item;

    // One unpacked input word.
    typedef struct packed {
        t_kind      kind;
        logic [6:0] device_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic       is_read;
        logic [7:0] write_data;
        logic       sda_in;
        logic       scl_in;
    } t_step_in;

    // One result word.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] read_data;
        logic       read_valid;
        logic       last_read;
        logic       done_res;
        logic       nack_error;
        logic       busy_res;
    } t_step_out;

endpackage

// ----- rtl/i2cmrt_ram.sv -----
module i2cmrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/i2cmrt_core.sv -----
module i2cmrt_core #(
    parameter int DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  i2cmrt_pkg::t_step_in  i_word,
    input  logic [7:0]            i_stretch_limit,
    output i2cmrt_pkg::t_step_out o_result
);
    import i2cmrt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);
    localparam logic [8:0]    DEPTH_9  = 9'(DEPTH);
    localparam logic [FW-1:0] DEPTH_FW = FW'(DEPTH);

    t_phase        r_phase, n_phase;
    t_item         r_item, n_item;
    logic [3:0]    r_bit_position, n_bit_position;
    logic [7:0]    r_shift_byte, n_shift_byte;
    logic [7:0]    r_byte_index, n_byte_index;
    logic [FW-1:0] r_buffer_fill, n_buffer_fill;
    logic [7:0]    r_stretch_count, n_stretch_count;
    logic [6:0]    r_target_address, n_target_address;
    logic [7:0]    r_target_register, n_target_register;
    logic [7:0]    r_transfer_length, n_transfer_length;
    logic          r_read_mode, n_read_mode;
    logic          r_error_flag, n_error_flag;
    logic          r_scl, n_scl;
    logic          r_sda, n_sda;

    logic          buf_we;
    logic [AW-1:0] buf_raddr;
    logic [7:0]    buf_rdata;
    logic          stretch_go;
    logic          last_byte;
    logic [7:0]    next_index;
    logic [7:0]    start_count;
    logic [3:0]    bit_inc;
    t_step_out     result;

    // Write buffer; the read side always presents the next byte to be sent.
    i2cmrt_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_buffer (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_buffer_fill[AW-1:0]),
        .i_wdata (i_word.write_data),
        .i_raddr (buf_raddr),
        .o_rdata (buf_rdata)
    );

    // The next index holds steady through the bit phases of a byte before it is used, so the
    // registered read has long settled by the acknowledge phase.
    assign next_index = r_byte_index + 8'd1;
    assign buf_raddr  = (r_item == ITEM_DATA) ? AW'(next_index) : '0;

    // Helper terms; most are shared by several phases.
    assign stretch_go = i_word.scl_in || (r_stretch_count >= i_stretch_limit);
    assign last_byte  = (r_transfer_length != 8'd0) &&
                        (r_byte_index == r_transfer_length - 8'd1);
    assign bit_inc    = r_bit_position + 4'd1;
    assign start_count = (!i_word.is_read && ({1'b0, i_word.byte_count} > DEPTH_9)) ?
                         DEPTH_9[7:0] : i_word.byte_count;

    // Next-state and result logic for one word.
    always_comb begin
        n_phase           = r_phase;
        n_item            = r_item;
        n_bit_position    = r_bit_position;
        n_shift_byte      = r_shift_byte;
        n_byte_index      = r_byte_index;
        n_buffer_fill     = r_buffer_fill;
        n_stretch_count   = r_stretch_count;
        n_target_address  = r_target_address;
        n_target_register = r_target_register;
        n_transfer_length = r_transfer_length;
        n_read_mode       = r_read_mode;
        n_error_flag      = r_error_flag;
        n_scl             = r_scl;
        n_sda             = r_sda;
        buf_we            = 1'b0;
        result            = '0;

        case (i_word.kind)
            KIND_LOAD: begin
                if (r_phase == PH_IDLE && r_buffer_fill < DEPTH_FW) begin
                    buf_we        = i_step;
                    n_buffer_fill = r_buffer_fill + FW'(1);
                end
            end
            KIND_START: begin
                if (r_phase == PH_IDLE) begin
                    n_target_address  = i_word.device_address;
                    n_target_register = i_word.register_address;
                    n_read_mode       = i_word.is_read;
                    if (!i_word.is_read) begin
                        n_buffer_fill = '0;
                    end
                    n_transfer_length = start_count;
                    n_error_flag      = 1'b0;
                    n_byte_index      = '0;
                    n_bit_position    = '0;
                    n_shift_byte      = '0;
                    n_stretch_count   = '0;
                    n_item            = ITEM_ADDR_W;
                    n_phase           = PH_ST_A;
                end
            end
            KIND_TICK: begin
                case (r_phase)
                    PH_ST_A: begin
                        n_scl = 1'b1; n_sda = 1'b1; n_phase = PH_ST_B;
                    end
                    PH_ST_B: begin
                        n_scl = 1'b1; n_sda = 1'b0; n_phase = PH_ST_C;
                    end
                    PH_ST_C: begin
                        n_scl          = 1'b0;
                        n_sda          = 1'b0;
                        n_shift_byte   = {r_target_address, r_item == ITEM_ADDR_R};
                        n_bit_position = '0;
                        n_phase        = PH_TX_SET;
                    end
                    PH_TX_SET: begin
                        n_scl = 1'b0; n_sda = r_shift_byte[7]; n_phase = PH_TX_HIGH;
                    end
                    PH_TX_HIGH: begin
                        n_scl = 1'b1;
                        n_sda = r_shift_byte[7];
                        n_stretch_count = stretch_go ? 8'd0 : r_stretch_count + 8'd1;
                        if (stretch_go) begin
                            n_phase = PH_TX_LOW;
                        end
                    end
                    PH_TX_LOW: begin
                        n_scl          = 1'b0;
                        n_sda          = r_shift_byte[7];
                        n_shift_byte   = {r_shift_byte[6:0], 1'b0};
                        n_bit_position = bit_inc;
                        n_phase        = bit_inc[3] ? PH_ACK_SET : PH_TX_SET;
                    end
                    PH_ACK_SET: begin
                        n_scl = 1'b0; n_sda = 1'b1; n_phase = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH: begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                        n_stretch_count = stretch_go ? 8'd0 : r_stretch_count + 8'd1;
                        if (stretch_go) begin
                            if (i_word.sda_in) begin
                                n_error_flag = 1'b1;
                            end
                            n_phase = PH_ACK_LOW;
                        end
                    end
                    PH_ACK_LOW: begin
                        n_scl = 1'b0;
                        n_sda = 1'b1;
                        // Choose the next byte or a repeated START, or head for STOP on a NACK or at the end.
                        if (r_error_flag) begin
                            n_phase = PH_SP_A;
                        end else begin
                            case (r_item)
                                ITEM_ADDR_W: begin
                                    n_item         = ITEM_REG;
                                    n_shift_byte   = r_target_register;
                                    n_bit_position = '0;
                                    n_phase        = PH_TX_SET;
                                end
                                ITEM_REG: begin
                                    if (r_read_mode) begin
                                        n_item  = ITEM_ADDR_R;
                                        n_phase = PH_ST_A;
                                    end else if (r_transfer_length != 8'd0) begin
                                        n_item         = ITEM_DATA;
                                        n_byte_index   = '0;
                                        n_shift_byte   = buf_rdata;
                                        n_bit_position = '0;
                                        n_phase        = PH_TX_SET;
                                    end else begin
                                        n_phase = PH_SP_A;
                                    end
                                end
                                ITEM_DATA: begin
                                    n_byte_index = next_index;
                                    if (next_index < r_transfer_length) begin
                                        n_shift_byte   = buf_rdata;
                                        n_bit_position = '0;
                                        n_phase        = PH_TX_SET;
                                    end else begin
                                        n_phase = PH_SP_A;
                                    end
                                end
                                default: begin
                                    if (r_transfer_length != 8'd0) begin
                                        n_byte_index   = '0;
                                        n_bit_position = '0;
                                        n_shift_byte   = '0;
                                        n_phase        = PH_RX_HIGH;
                                    end else begin
                                        n_phase = PH_SP_A;
                                    end
                                end
                            endcase
                        end
                    end
                    PH_RX_HIGH: begin
                        n_scl = 1'b1;
                        n_sda = 1'b1;
                        n_stretch_count = stretch_go ? 8'd0 : r_stretch_count + 8'd1;
                        if (stretch_go) begin
                            n_shift_byte = {r_shift_byte[6:0], i_word.sda_in};
                            n_phase      = PH_RX_LOW;
                        end
                    end
                    PH_RX_LOW: begin
                        n_scl          = 1'b0;
                        n_sda          = 1'b1;
                        n_bit_position = bit_inc;
                        n_phase        = bit_inc[3] ? PH_MA_SET : PH_RX_HIGH;
                    end
                    PH_MA_SET: begin
                        n_scl = 1'b0; n_sda = last_byte; n_phase = PH_MA_HIGH;
                    end
                    PH_MA_HIGH: begin
                        n_scl = 1'b1;
                        n_sda = last_byte;
                        n_stretch_count = stretch_go ? 8'd0 : r_stretch_count + 8'd1;
                        if (stretch_go) begin
                            n_phase = PH_MA_LOW;
                        end
                    end
                    PH_MA_LOW: begin
                        n_scl             = 1'b0;
                        n_sda             = last_byte;
                        result.read_data  = r_shift_byte;
                        result.read_valid = 1'b1;
                        result.last_read  = last_byte;
                        if (last_byte) begin
                            n_phase = PH_SP_A;
                        end else begin
                            n_byte_index   = next_index;
                            n_bit_position = '0;
                            n_shift_byte   = '0;
                            n_phase        = PH_RX_HIGH;
                        end
                    end
                    PH_SP_A: begin
                        n_scl = 1'b0; n_sda = 1'b0; n_phase = PH_SP_B;
                    end
                    PH_SP_B: begin
                        n_scl = 1'b1;
                        n_sda = 1'b0;
                        n_stretch_count = stretch_go ? 8'd0 : r_stretch_count + 8'd1;
                        if (stretch_go) begin
                            n_phase = PH_SP_C;
                        end
                    end
                    PH_SP_C: begin
                        n_scl             = 1'b1;
                        n_sda             = 1'b1;
                        result.done_res   = 1'b1;
                        result.nack_error = r_error_flag;
                        n_phase           = PH_IDLE;
                    end
                    default: begin
                        n_scl = 1'b1; n_sda = 1'b1; n_phase = PH_IDLE;
                    end
                endcase
            end
            default: begin
            end
        endcase

        result.scl_out  = n_scl;
        result.sda_out  = n_sda;
        result.busy_res = (n_phase != PH_IDLE);
    end

    // State advances only on an accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_item            <= ITEM_ADDR_W;
            r_bit_position    <= '0;
            r_shift_byte      <= '0;
            r_byte_index      <= '0;
            r_buffer_fill     <= '0;
            r_stretch_count   <= '0;
            r_target_address  <= '0;
            r_target_register <= '0;
            r_transfer_length <= '0;
            r_read_mode       <= 1'b0;
            r_error_flag      <= 1'b0;
            r_scl             <= 1'b1;
            r_sda             <= 1'b1;
        end else if (i_step) begin
            r_phase           <= n_phase;
            r_item            <= n_item;
            r_bit_position    <= n_bit_position;
            r_shift_byte      <= n_shift_byte;
            r_byte_index      <= n_byte_index;
            r_buffer_fill     <= n_buffer_fill;
            r_stretch_count   <= n_stretch_count;
            r_target_address  <= n_target_address;
            r_target_register <= n_target_register;
            r_transfer_length <= n_transfer_length;
            r_read_mode       <= n_read_mode;
            r_error_flag      <= n_error_flag;
            r_scl             <= n_scl;
            r_sda             <= n_sda;
        end
    end

    assign o_result = result;

endmodule

// ----- rtl/i2c_master_register_transfer.sv -----
// Output: a result word is registered and presented in the cycle after its input word is accepted.
// Throughput: one input word per clock cycle; the output register frees itself in the
// same cycle that its word is taken, so a stalled master side alone holds back input.
// Reset: synchronous, active low; the bus is idle with both lines released, the
// buffer fill is empty and the stretch limit returns to 200 ticks.
module i2c_master_register_transfer #(
    parameter int WRITE_BUFFER_DEPTH = i2cmrt_pkg::WRITE_BUFFER_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // From bit 0: device_address[6:0], register_address[14:7], byte_count[22:15],
    // is_read[23], write_data[31:24], sda_in[32], scl_in[33], zero padding.
    input  logic [i2cmrt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind (0 load write byte, 1 start transaction, 2 bus tick).
    input  logic [i2cmrt_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // From bit 0: scl_out[0], sda_out[1], read_data[9:2], read_valid[10],
    // done_res[11], nack_error[12], busy_res[13], zero padding.
    output logic [i2cmrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // last_read.
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_wr_en,
    input  logic [7:0]                         i_cfg_wr_data
);
    import i2cmrt_pkg::*;

    logic       r_out_valid;
    t_step_out  r_out;
    logic [7:0] r_stretch_limit;
    logic       in_accept;
    t_step_in   in_word;
    t_step_out  core_result;

    // Input word unpacking.
    assign in_word.kind             = t_kind'(s_axis_tuser);
    assign in_word.device_address   = s_axis_tdata[6:0];
    assign in_word.register_address = s_axis_tdata[14:7];
    assign in_word.byte_count       = s_axis_tdata[22:15];
    assign in_word.is_read          = s_axis_tdata[23];
    assign in_word.write_data       = s_axis_tdata[31:24];
    assign in_word.sda_in           = s_axis_tdata[32];
    assign in_word.scl_in           = s_axis_tdata[33];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Stretch limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stretch_limit <= STRETCH_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_stretch_limit <= i_cfg_wr_data;
        end
    end

    i2cmrt_core #(
        .DEPTH (WRITE_BUFFER_DEPTH)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (in_accept),
        .i_word          (in_word),
        .i_stretch_limit (r_stretch_limit),
        .o_result        (core_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.busy_res, r_out.nack_error, r_out.done_res,
                            r_out.read_valid, r_out.read_data, r_out.sda_out, r_out.scl_out};
    assign m_axis_tlast  = r_out.last_read;

    // A completed STOP leaves the master idle.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done word reports busy");

    // An error is only reported with the STOP that ends the transaction.
    a_nack_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.nack_error) |-> r_out.done_res)
        else $error("nack error without done");

    // A received byte never coincides with STOP, and last marks a received byte.
    a_read_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.read_valid || r_out.last_read)) |->
            (r_out.read_valid && !r_out.done_res && r_out.busy_res))
        else $error("inconsistent read flags");

    // A load or start word leaves the bus lines where they were.
    a_lines_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (in_word.kind == KIND_LOAD || in_word.kind == KIND_START)) |=>
            ({r_out.sda_out, r_out.scl_out} == $past({u_core.r_sda, u_core.r_scl})))
        else $error("line drive changed on a non-tick word");

endmodule
